FILE: sv/checksummed_frame_deframer_defines.svh
// assertion macros shared by the deframer checks
`ifndef CHECKSUMMED_FRAME_DEFRAMER_DEFINES_SVH
`define CHECKSUMMED_FRAME_DEFRAMER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define CFD_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// next-cycle implication, sampled on clk, off while in reset
`define CFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

FILE: sv/cfd_pkg.sv
package cfd_pkg;

    localparam int unsigned POS_W = 8;
    localparam int unsigned LEN_W = 7;

    localparam logic [2:0] KIND_START   = 3'd0;
    localparam logic [2:0] KIND_LENGTH  = 3'd1;
    localparam logic [2:0] KIND_TYPE    = 3'd2;
    localparam logic [2:0] KIND_COMMAND = 3'd3;
    localparam logic [2:0] KIND_PARAM   = 3'd4;
    localparam logic [2:0] KIND_CHECK   = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_BADLEN   = 2'd2;

    localparam logic [7:0] CHECK_SEED = 8'hFF;
    localparam logic [7:0] LEN_MIN    = 8'd3;
    localparam logic [7:0] LEN_MAX    = 8'd127;

    typedef struct packed {
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic [2:0] byte_kind;
        logic [6:0] param_index;
        logic       frame_end;
        logic [1:0] frame_status;
    } out_item_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } held_byte_t;

endpackage

FILE: sv/cfd_stream_if.sv
interface cfd_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

FILE: sv/cfd_input_stage.sv
module cfd_input_stage (
    input  logic                clk,
    input  logic                rst_n,
    cfd_stream_if.sink          rx,
    input  logic                advance,
    output cfd_pkg::held_byte_t held
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       rx_take;

    assign rx.ready = !valid_reg || advance;
    assign rx_take  = rx.valid && rx.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b0;
        end
        if (rx_take)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
        begin
            data_reg <= rx.payload.data_byte;
        end
    end

    assign held.valid = valid_reg;
    assign held.data  = data_reg;

endmodule

FILE: sv/cfd_frame_tracker.sv
module cfd_frame_tracker (
    input  logic                clk,
    input  logic                rst_n,
    input  cfd_pkg::held_byte_t held,
    output logic                advance,
    cfd_stream_if.source        res
);

    logic [cfd_pkg::POS_W-1:0] pos_reg;
    logic [cfd_pkg::POS_W-1:0] pos_next;
    logic [cfd_pkg::LEN_W-1:0] len_reg;
    logic [cfd_pkg::LEN_W-1:0] len_next;
    logic [7:0]                chk_reg;
    logic [7:0]                chk_next;
    logic                      res_valid_reg;
    logic                      res_valid_next;
    cfd_pkg::out_item_t        res_item_reg;
    cfd_pkg::out_item_t        res_item_next;
    logic [cfd_pkg::POS_W-1:0] param_off;
    logic                      take;

    assign advance   = !res_valid_reg || res.ready;
    assign take      = held.valid && advance;
    assign param_off = pos_reg - cfd_pkg::POS_W'(4);

    // byte classification and frame state update
    always_comb
    begin
        pos_next                   = pos_reg;
        len_next                   = len_reg;
        chk_next                   = chk_reg;
        res_item_next.byte_value   = held.data;
        res_item_next.byte_kind    = cfd_pkg::KIND_START;
        res_item_next.param_index  = '0;
        res_item_next.frame_end    = 1'b0;
        res_item_next.frame_status = cfd_pkg::ST_OK;

        if (pos_reg == cfd_pkg::POS_W'(0))
        begin
            chk_next = cfd_pkg::CHECK_SEED;
            len_next = '0;
            pos_next = cfd_pkg::POS_W'(1);
        end
        else if (pos_reg == cfd_pkg::POS_W'(1))
        begin
            res_item_next.byte_kind = cfd_pkg::KIND_LENGTH;
            if ((held.data < cfd_pkg::LEN_MIN) || (held.data > cfd_pkg::LEN_MAX))
            begin
                res_item_next.frame_end    = 1'b1;
                res_item_next.frame_status = cfd_pkg::ST_BADLEN;
                pos_next                   = '0;
                len_next                   = '0;
                chk_next                   = cfd_pkg::CHECK_SEED;
            end
            else
            begin
                len_next = held.data[cfd_pkg::LEN_W-1:0];
                chk_next = cfd_pkg::CHECK_SEED ^ held.data;
                pos_next = cfd_pkg::POS_W'(2);
            end
        end
        else if (pos_reg <= {1'b0, len_reg})
        begin
            if (pos_reg == cfd_pkg::POS_W'(2))
            begin
                res_item_next.byte_kind = cfd_pkg::KIND_TYPE;
            end
            else if (pos_reg == cfd_pkg::POS_W'(3))
            begin
                res_item_next.byte_kind = cfd_pkg::KIND_COMMAND;
            end
            else
            begin
                res_item_next.byte_kind   = cfd_pkg::KIND_PARAM;
                res_item_next.param_index = param_off[6:0];
            end
            chk_next = chk_reg ^ held.data;
            pos_next = pos_reg + cfd_pkg::POS_W'(1);
        end
        else
        begin
            res_item_next.byte_kind    = cfd_pkg::KIND_CHECK;
            res_item_next.frame_end    = 1'b1;
            res_item_next.frame_status = (held.data == chk_reg) ? cfd_pkg::ST_OK
                                                                : cfd_pkg::ST_MISMATCH;
            pos_next                   = '0;
            len_next                   = '0;
            chk_next                   = cfd_pkg::CHECK_SEED;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = held.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            len_reg       <= '0;
            chk_reg       <= cfd_pkg::CHECK_SEED;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (take)
            begin
                pos_reg <= pos_next;
                len_reg <= len_next;
                chk_reg <= chk_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_item_reg <= res_item_next;
        end
    end

    assign res.valid   = res_valid_reg;
    assign res.payload = res_item_reg;

endmodule

FILE: sv/checksummed_frame_deframer.sv
// Splits a received byte stream into length-prefixed frames (start, length L, type,
// command, L-3 parameters, XOR checksum seeded with 0xff) and classifies every byte
// with one result transfer on res. One byte is taken per clock cycle, sustained,
// while res is not stalled; each result is registered in the input stage's held
// byte and then in the tracker's result register. The rate is set by the frame
// position, length and running XOR registers, which are updated once per byte.
// Length bytes below 3 or above 127 end the frame at once with bad-length status;
// after any frame end the next byte is taken as a start byte.
module checksummed_frame_deframer (
    input  logic        clk,
    input  logic        rst_n,
    cfd_stream_if.sink  rx,
    cfd_stream_if.source res
);

    cfd_pkg::held_byte_t held;
    logic                advance;

    cfd_input_stage u_input_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx),
        .advance (advance),
        .held    (held)
    );

    cfd_frame_tracker u_frame_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .held    (held),
        .advance (advance),
        .res     (res)
    );

endmodule

FILE: sv/cfd_checker.sv
`include "checksummed_frame_deframer_defines.svh"

module cfd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               rx_valid,
    input logic               rx_ready,
    input logic               res_valid,
    input logic               res_ready,
    input cfd_pkg::out_item_t res_payload
);

    // status only carries meaning at a frame end
    `CFD_ASSERT_IMPLY(a_status_only_at_end, res_valid && !res_payload.frame_end, res_payload.frame_status == cfd_pkg::ST_OK)

    // frames end only on a checksum byte or a rejected length byte
    `CFD_ASSERT_IMPLY(a_end_kind, res_valid && res_payload.frame_end, res_payload.byte_kind == cfd_pkg::KIND_CHECK || res_payload.byte_kind == cfd_pkg::KIND_LENGTH)

    // parameter index is zero outside parameter bytes
    `CFD_ASSERT_IMPLY(a_param_index_zero, res_valid && res_payload.byte_kind != cfd_pkg::KIND_PARAM, res_payload.param_index == 7'd0)

    // a stalled result holds
    `CFD_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_payload))

    // a refused byte stays offered
    `CFD_ASSERT_NEXT(a_rx_hold, rx_valid && !rx_ready, rx_valid)

endmodule

bind checksummed_frame_deframer cfd_checker u_cfd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rx_valid    (rx.valid),
    .rx_ready    (rx.ready),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .res_payload (res.payload)
);

FILE: tb/sv/tb_checksummed_frame_deframer.sv
module tb_checksummed_frame_deframer;

    import cfd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RANDOM_BYTES = 850;
    localparam int unsigned TAIL_BYTES = 120;
    localparam int unsigned HOLD_AT_RESULT = 300;
    localparam int unsigned HOLD_CYCLES = 150;
    localparam int unsigned DRAIN_CYCLES = 20;

    logic clk;
    logic rst_n;

    cfd_stream_if #(.payload_t(in_item_t))  rx_if ();
    cfd_stream_if #(.payload_t(out_item_t)) res_if ();

    checksummed_frame_deframer i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .res   (res_if)
    );

    // predicted deframer state
    logic [7:0] frame_pos;
    logic [6:0] frame_len;
    logic [7:0] frame_sum;

    logic [7:0] pending_bytes[$];
    out_item_t  expected_results[$];

    int unsigned fail_count;
    int unsigned cycle_count;
    int unsigned bytes_sent;
    int unsigned results_seen;
    int unsigned send_gap;
    int unsigned recv_stall;
    int unsigned hold_left;
    bit          hold_done;
    bit          tail_phase;

    always #6 clk = ~clk;

    function automatic out_item_t classify_byte(input logic [7:0] d);
        out_item_t r;
        r = '0;
        r.byte_value = d;
        if (frame_pos == 8'd0)
        begin
            r.byte_kind = KIND_START;
            frame_sum = CHECK_SEED;
            frame_len = '0;
            frame_pos = 8'd1;
        end
        else if (frame_pos == 8'd1)
        begin
            r.byte_kind = KIND_LENGTH;
            if (d < LEN_MIN || d > LEN_MAX)
            begin
                r.frame_end = 1'b1;
                r.frame_status = ST_BADLEN;
                frame_pos = 8'd0;
                frame_len = '0;
                frame_sum = CHECK_SEED;
            end
            else
            begin
                frame_len = d[6:0];
                frame_sum = CHECK_SEED ^ d;
                frame_pos = 8'd2;
            end
        end
        else if (frame_pos <= {1'b0, frame_len})
        begin
            if (frame_pos == 8'd2)
                r.byte_kind = KIND_TYPE;
            else if (frame_pos == 8'd3)
                r.byte_kind = KIND_COMMAND;
            else
            begin
                r.byte_kind = KIND_PARAM;
                r.param_index = 7'(frame_pos - 8'd4);
            end
            frame_sum = frame_sum ^ d;
            frame_pos = frame_pos + 8'd1;
        end
        else
        begin
            r.byte_kind = KIND_CHECK;
            r.frame_end = 1'b1;
            r.frame_status = (d == frame_sum) ? ST_OK : ST_MISMATCH;
            frame_pos = 8'd0;
            frame_len = '0;
            frame_sum = CHECK_SEED;
        end
        return r;
    endfunction

    // a bad length ends the frame straight after the length byte
    task automatic queue_frame(input logic [7:0] start, input logic [7:0] len,
                               input bit corrupt);
        logic [7:0] sum;
        logic [7:0] b;
        pending_bytes.push_back(start);
        pending_bytes.push_back(len);
        if (len >= LEN_MIN && len <= LEN_MAX)
        begin
            sum = CHECK_SEED ^ len;
            for (int i = 2; i <= int'(len); i++)
            begin
                b = 8'($urandom);
                pending_bytes.push_back(b);
                sum = sum ^ b;
            end
            if (corrupt)
                sum = sum ^ 8'($urandom_range(1, 255));
            pending_bytes.push_back(sum);
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        logic offer;
        if (!rst_n)
        begin
            rx_if.valid <= 1'b0;
            rx_if.payload <= '0;
            send_gap = 0;
            bytes_sent = 0;
            tail_phase <= 1'b0;
        end
        else
        begin
            if (rx_if.valid && rx_if.ready)
            begin
                expected_results.push_back(classify_byte(rx_if.payload.data_byte));
                void'(pending_bytes.pop_front());
                bytes_sent++;
            end
            if (rx_if.valid && !rx_if.ready)
                offer = 1'b1;
            else if (send_gap != 0)
            begin
                send_gap--;
                offer = 1'b0;
            end
            else if (pending_bytes.size() == 0)
                offer = 1'b0;
            else if (!tail_phase && hold_left == 0 && (bytes_sent / 64) % 3 != 0
                     && $urandom_range(0, 5) == 0)
            begin
                send_gap = $urandom_range(1, 12) - 1;
                offer = 1'b0;
            end
            else
                offer = 1'b1;
            rx_if.valid <= offer;
            if (offer)
                rx_if.payload.data_byte <= pending_bytes[0];
            tail_phase <= pending_bytes.size() < TAIL_BYTES;
        end
    end

    // receiver and result check
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        out_item_t got;
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            recv_stall = 0;
            results_seen = 0;
            hold_left <= 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                got = res_if.payload;
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result transfer, byte_value %0h", got.byte_value);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.byte_value !== want.byte_value)
                    begin
                        $error("byte_value: expected %0d, actual %0d",
                               want.byte_value, got.byte_value);
                        fail_count++;
                    end
                    if (got.byte_kind !== want.byte_kind)
                    begin
                        $error("byte_kind: expected %0d, actual %0d",
                               want.byte_kind, got.byte_kind);
                        fail_count++;
                    end
                    if (got.param_index !== want.param_index)
                    begin
                        $error("param_index: expected %0d, actual %0d",
                               want.param_index, got.param_index);
                        fail_count++;
                    end
                    if (got.frame_end !== want.frame_end)
                    begin
                        $error("frame_end: expected %0d, actual %0d",
                               want.frame_end, got.frame_end);
                        fail_count++;
                    end
                    if (got.frame_status !== want.frame_status)
                    begin
                        $error("frame_status: expected %0d, actual %0d",
                               want.frame_status, got.frame_status);
                        fail_count++;
                    end
                end
            end
            // one long hold-off so the input side backs up
            if (!hold_done && results_seen >= HOLD_AT_RESULT)
            begin
                hold_done = 1'b1;
                hold_left <= HOLD_CYCLES;
                res_if.ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                res_if.ready <= 1'b0;
            end
            else if (recv_stall != 0)
            begin
                recv_stall--;
                res_if.ready <= 1'b0;
            end
            else if (!tail_phase && (results_seen / 80) % 3 != 1
                     && $urandom_range(0, 5) == 0)
            begin
                recv_stall = $urandom_range(1, 12) - 1;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int unsigned r;
        logic [7:0] len;
        clk = 1'b0;
        rst_n = 1'b0;
        rx_if.valid = 1'b0;
        rx_if.payload = '0;
        res_if.ready = 1'b0;
        fail_count = 0;
        cycle_count = 0;
        frame_pos = 8'd0;
        frame_len = '0;
        frame_sum = CHECK_SEED;

        // minimum frame, bad lengths at both edges, bad checksum, one parameter
        queue_frame(8'h00, 8'd3, 1'b0);
        queue_frame(8'hFF, 8'd2, 1'b0);
        queue_frame(8'h5A, 8'd0, 1'b0);
        queue_frame(8'hA5, 8'd128, 1'b0);
        queue_frame(8'h01, 8'd255, 1'b0);
        queue_frame(8'h80, 8'd3, 1'b1);
        queue_frame(8'h7F, 8'd4, 1'b0);

        // random part: mostly sound frames, some noise
        queue_frame(8'($urandom), LEN_MAX, 1'b0);
        while (pending_bytes.size() < RANDOM_BYTES)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                len = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 2))
                                                  : 8'($urandom_range(128, 255));
                queue_frame(8'($urandom), len, 1'b0);
            end
            else if (r < 13)
                queue_frame(8'($urandom), 8'($urandom), $urandom_range(0, 1) == 1);
            else if (r < 14)
                queue_frame(8'($urandom), 8'($urandom_range(60, 127)), 1'b0);
            else
                queue_frame(8'($urandom), 8'($urandom_range(3, 12)),
                            $urandom_range(0, 9) == 0);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
